// ===== rtl/core/qbi_pkg.sv =====
// Shared types, constants and weight function for the quarter-pel block interpolator.
package qbi_pkg;

  localparam int unsigned NumLanes = 4;
  localparam logic [2:0] RowsPerBlock = 3'd4;
  localparam logic [3:0] RoundBase = 4'd8;

  typedef struct packed {
    logic [4:0] wa;
    logic [4:0] wb;
    logic [4:0] wc;
    logic [4:0] wd;
  } qbi_wt_t;

  typedef struct packed {
    qbi_wt_t     wt;
    logic [3:0]  rnd;
    logic        avg;
  } qbi_ctl_t;

  // Bilinear weights for one quarter-pel offset pair; they always sum to 16.
  function automatic qbi_wt_t qbi_weights(input logic [1:0] fx, input logic [1:0] fy);
    logic [2:0] ax;
    logic [2:0] ay;
    logic [2:0] bx;
    logic [2:0] by;
    qbi_wt_t    w;
    ax = 3'd4 - {1'b0, fx};
    ay = 3'd4 - {1'b0, fy};
    bx = {1'b0, fx};
    by = {1'b0, fy};
    w.wa = {2'b00, ax} * {2'b00, ay};
    w.wb = {2'b00, bx} * {2'b00, ay};
    w.wc = {2'b00, ax} * {2'b00, by};
    w.wd = {2'b00, bx} * {2'b00, by};
    return w;
  endfunction

endpackage

// ===== rtl/core/qbi_lane.sv =====
// One output column: bilinear blend of four pixels, rounding and optional averaging.
module qbi_lane
  import qbi_pkg::*;
(
  input  logic [15:0] prev_pair_i,
  input  logic [15:0] cur_pair_i,
  input  logic [7:0]  dst_byte_i,
  input  qbi_ctl_t    ctl_i,
  output logic [7:0]  pix_o
);

  logic [11:0] prod_a;
  logic [11:0] prod_b;
  logic [11:0] prod_c;
  logic [11:0] prod_d;
  logic [11:0] sum;
  logic [7:0]  interp;
  logic [8:0]  avg_sum;

  // The weights sum to 16, so the total never exceeds 255 * 16 + 8.
  assign prod_a = {4'b0, prev_pair_i[7:0]}  * {7'b0, ctl_i.wt.wa};
  assign prod_b = {4'b0, prev_pair_i[15:8]} * {7'b0, ctl_i.wt.wb};
  assign prod_c = {4'b0, cur_pair_i[7:0]}   * {7'b0, ctl_i.wt.wc};
  assign prod_d = {4'b0, cur_pair_i[15:8]}  * {7'b0, ctl_i.wt.wd};
  assign sum    = prod_a + prod_b + prod_c + prod_d + {8'b0, ctl_i.rnd};
  assign interp = sum[11:4];

  assign avg_sum = {1'b0, interp} + {1'b0, dst_byte_i} + 9'd1;
  assign pix_o   = ctl_i.avg ? avg_sum[8:1] : interp;

endmodule

// ===== rtl/core/qbi_out_reg.sv =====
// Output register that merges the lane bytes into one row and holds it under stall.
module qbi_out_reg
  import qbi_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [NumLanes*8-1:0]   row_i,
  input  logic                    last_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [NumLanes*8-1:0]   out_row_o,
  output logic                    last_row_o
);

  logic                  valid_q;
  logic                  valid_d;
  logic [NumLanes*8-1:0] row_q;
  logic                  last_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      row_q  <= row_i;
      last_q <= last_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_row_o   = row_q;
  assign last_row_o  = last_q;

endmodule

// ===== rtl/core/qpel_bilinear_block_interp.sv =====
// Top level of the quarter-pel bilinear 4x4 block interpolator.
//
// Usage: a fetcher streams a block as five source rows of five bytes on the
// input channel (in_valid_i / in_stall_o), the first one flagged by first_row_i.
// A word is taken at a rising edge where in_valid_i is high and in_stall_o low.
// The first row is only stored; each of the next four rows yields one word of
// four interpolated bytes on the output channel (out_valid_o / out_stall_i),
// and the fourth carries last_row_o. Rows beyond the fourth that are not
// flagged first give no word. Offsets, rounding and mode are taken per row.
// Four lanes compute the four columns in parallel and an output register
// merges their bytes into the result word.
// The edge that takes a source row loads the lane stage; the word then moves
// into the output register once that register is free, and from there it
// goes to the receiver.
// Throughput is one row per cycle while the receiver does not stall, set by
// the lane stage and the output register both advancing every cycle then.
// Reset clears the stored row to zero bytes, the row count and both valid
// flags. When the receiver stalls, the output word holds; the lane stage
// still fills, and only when both are full does in_stall_o rise.
module qpel_bilinear_block_interp
  import qbi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_row_i,
  input  logic [39:0] src_row_i,
  input  logic [31:0] dst_row_i,
  input  logic [1:0]  frac_x_i,
  input  logic [1:0]  frac_y_i,
  input  logic        round_down_i,
  input  logic        mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_row_o,
  output logic        last_row_o
);

  // Row state that carries from one accepted word to the next.
  logic [39:0] prev_row_q;
  logic [2:0]  rows_q;
  logic [2:0]  rows_d;

  // Lane stage registers.
  logic        s1_valid_q;
  logic        s1_valid_d;
  logic [39:0] s1_prev_q;
  logic [39:0] s1_cur_q;
  logic [31:0] s1_dst_q;
  qbi_ctl_t    s1_ctl_q;
  logic        s1_last_q;

  logic        in_fire;
  logic        emit;
  logic        out_ready;
  qbi_ctl_t    ctl_d;
  logic [31:0] lane_row;

  assign in_fire    = in_valid_i && !in_stall_o;
  // A non-first row produces a word only while the block still owes rows.
  assign emit       = in_fire && !first_row_i && (rows_q < RowsPerBlock);
  // The lane stage can load whenever it is empty or its word moves on.
  assign in_stall_o = s1_valid_q && !out_ready;

  always_comb begin
    ctl_d.wt  = qbi_weights(frac_x_i, frac_y_i);
    // Averaging always uses the full rounding constant.
    ctl_d.rnd = RoundBase - {3'b000, round_down_i & ~mode_i};
    ctl_d.avg = mode_i;
  end

  always_comb begin
    rows_d = rows_q;
    if (in_fire && first_row_i) begin
      rows_d = 3'd0;
    end else if (emit) begin
      rows_d = rows_q + 3'd1;
    end
  end

  assign s1_valid_d = in_stall_o ? s1_valid_q : emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_row_q <= '0;
      rows_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_fire && (first_row_i || emit)) begin
        prev_row_q <= src_row_i;
      end
      rows_q     <= rows_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_prev_q <= prev_row_q;
      s1_cur_q  <= src_row_i;
      s1_dst_q  <= dst_row_i;
      s1_ctl_q  <= ctl_d;
      s1_last_q <= (rows_q + 3'd1) == RowsPerBlock;
    end
  end

  // One lane per output column; lane k reads bytes k and k+1 of both rows.
  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    qbi_lane u_lane (
      .prev_pair_i (s1_prev_q[8*k +: 16]),
      .cur_pair_i  (s1_cur_q[8*k +: 16]),
      .dst_byte_i  (s1_dst_q[8*k +: 8]),
      .ctl_i       (s1_ctl_q),
      .pix_o       (lane_row[8*k +: 8])
    );
  end

  qbi_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid_q),
    .row_i       (lane_row),
    .last_i      (s1_last_q),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_row_o   (out_row_o),
    .last_row_o  (last_row_o)
  );

  // The row count never runs past a full block.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rows_q <= RowsPerBlock)
    else $error("row count exceeds block height");

  // A first row restarts the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_fire && first_row_i |=> rows_q == 3'd0)
    else $error("first row did not clear the row count");

  // A row that owes a result always lands in the lane stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |=> s1_valid_q)
    else $error("emitted row lost before the lane stage");

  // Back-pressure only when both stages hold a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_stall_o |-> (s1_valid_q && out_valid_o))
    else $error("input stalled with a free stage");

endmodule

// ===== verif/tb_qpel_bilinear_block_interp.sv =====
// Self-checking testbench for the quarter-pel bilinear 4x4 block interpolator.
`timescale 1ns / 1ps

module tb_qpel_bilinear_block_interp;
  import qbi_pkg::*;

  // Mode codes for the per-row mode field.
  localparam logic ModeWrite = 1'b0;
  localparam logic ModeAvg   = 1'b1;

  // The watchdog limit is the number of cycles with no word moving on either
  // channel. Runs of random idling at 74 percent are short, and the longest
  // legal quiet stretch is the pass through both pipe registers plus the end drain.
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandomRows  = 1850;
  localparam int unsigned PhaseRows   = 160;

  // One source row as the fetcher would present it. The hold flag makes the
  // driver wait with this word until every expected result word has arrived.
  typedef struct {
    logic        first;
    logic [39:0] src;
    logic [31:0] dst;
    logic [1:0]  fx;
    logic [1:0]  fy;
    logic        rd;
    logic        avg;
    bit          hold;
  } src_word_t;

  typedef struct {
    logic [31:0] row;
    logic        last;
  } out_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        row_valid = 1'b0;
  logic        row_stall;
  logic        first_row = 1'b0;
  logic [39:0] src_row = '0;
  logic [31:0] dst_row = '0;
  logic [1:0]  frac_x = '0;
  logic [1:0]  frac_y = '0;
  logic        round_down = 1'b0;
  logic        mode = ModeWrite;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [31:0] res_row;
  logic        res_last;

  qpel_bilinear_block_interp dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (row_valid),
    .in_stall_o   (row_stall),
    .first_row_i  (first_row),
    .src_row_i    (src_row),
    .dst_row_i    (dst_row),
    .frac_x_i     (frac_x),
    .frac_y_i     (frac_y),
    .round_down_i (round_down),
    .mode_i       (mode),
    .out_valid_o  (res_valid),
    .out_stall_i  (res_stall),
    .out_row_o    (res_row),
    .last_row_o   (res_last)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  src_word_t   pending_rows[$];
  out_word_t   expected_rows[$];
  src_word_t   shown_word;
  int unsigned rows_taken = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Predictor state: the row the next blend uses as its upper neighbor, and
  // how many result rows the current block has produced. After reset the
  // stored row is all zero bytes, as if a zero first row had been taken.
  logic [39:0] stored_row = '0;
  logic [2:0]  rows_made = '0;

  // Idling phases follow the number of source words taken, so each setting
  // is applied over 160 words and the cycle repeats several times.
  always_comb begin
    case ((rows_taken / PhaseRows) % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 74;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 74;
      end
      default: begin
        send_idle_pct  = 35;
        recv_stall_pct = 35;
      end
    endcase
  end

  // One output row: each of the four bytes is the weighted sum of the two
  // neighbors in the stored row and the two in the current row. The weights
  // always sum to 16, so the shift by four brings the sum back to a byte.
  function automatic logic [31:0] blend_row(logic [39:0] upper, src_word_t w);
    int unsigned wa;
    int unsigned wb;
    int unsigned wc;
    int unsigned wd;
    int unsigned rnd;
    int unsigned sum;
    int unsigned pix;
    int unsigned k;
    logic [31:0] res;
    wa  = (4 - w.fx) * (4 - w.fy);
    wb  = w.fx * (4 - w.fy);
    wc  = (4 - w.fx) * w.fy;
    wd  = w.fx * w.fy;
    // Averaging always rounds up; only plain writes honor round_down.
    rnd = (w.avg == ModeAvg) ? 32'(RoundBase) : 32'(RoundBase) - 32'(w.rd);
    res = '0;
    for (k = 0; k < 4; k++) begin
      sum = upper[8*k +: 8] * wa + upper[8*(k+1) +: 8] * wb
          + w.src[8*k +: 8] * wc + w.src[8*(k+1) +: 8] * wd + rnd;
      pix = (sum >> 4) & 8'hFF;
      if (w.avg == ModeAvg) begin
        pix = (pix + w.dst[8*k +: 8] + 1) >> 1;
      end
      res[8*k +: 8] = pix[7:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Driver: presents words from the pending queue. A stalled word is held
  // unchanged; a new one is loaded only after the shown word was taken or
  // when the channel was idle. Each signal sees one assignment per edge.
  always @(posedge clk_i) begin : drive
    out_word_t nxt_out;
    src_word_t nxt;
    logic      taken;
    if (rst_ni) begin
      taken = row_valid && !row_stall;
      if (taken) begin
        rows_taken <= rows_taken + 1;
        if (shown_word.first) begin
          stored_row = shown_word.src;
          rows_made  = '0;
        end else if (rows_made < RowsPerBlock) begin
          nxt_out.row  = blend_row(stored_row, shown_word);
          rows_made    = rows_made + 3'd1;
          nxt_out.last = (rows_made == RowsPerBlock);
          expected_rows.push_back(nxt_out);
          stored_row   = shown_word.src;
        end
        // Rows past the fourth that are not marked first are dropped.
      end
      if (!row_valid || taken) begin
        if (pending_rows.size() != 0 &&
            !(pending_rows[0].hold && expected_rows.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_rows.pop_front();
          shown_word <= nxt;
          first_row  <= nxt.first;
          src_row    <= nxt.src;
          dst_row    <= nxt.dst;
          frac_x     <= nxt.fx;
          frac_y     <= nxt.fy;
          round_down <= nxt.rd;
          mode       <= nxt.avg;
          row_valid  <= 1'b1;
        end else begin
          row_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result word taken against the oldest prediction,
  // then picks the stall for the next cycle.
  always @(posedge clk_i) begin : watch
    out_word_t want;
    if (rst_ni) begin
      if (res_valid === 1'b1 && !res_stall) begin
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", res_row));
        end else begin
          want = expected_rows.pop_front();
          if (res_row !== want.row) begin
            report_mismatch($sformatf("out_row %h, predicted %h", res_row, want.row));
          end
          if (res_last !== want.last) begin
            report_mismatch($sformatf("last_row %b, predicted %b", res_last, want.last));
          end
        end
      end
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake or a lost result shows up as a long stretch
  // in which no word moves on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((row_valid && !row_stall) || (res_valid === 1'b1 && !res_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic push_word(logic first, logic [39:0] src, logic [31:0] dst,
                           logic [1:0] fx, logic [1:0] fy, logic rd, logic avg,
                           bit hold = 1'b0);
    src_word_t w;
    w.first = first;
    w.src   = src;
    w.dst   = dst;
    w.fx    = fx;
    w.fy    = fy;
    w.rd    = rd;
    w.avg   = avg;
    w.hold  = hold;
    pending_rows.push_back(w);
  endtask

  // Source bytes lean toward the extremes so that saturated sums and the
  // rounding edges come up often.
  function automatic logic [39:0] pick_src();
    logic [39:0] v;
    int unsigned k;
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      2: begin
        for (k = 0; k < 5; k++) v[8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      default: v = 40'({$urandom(), $urandom()});
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_dst();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    int unsigned made;
    int unsigned blk;
    int unsigned kind;
    int unsigned n;
    int unsigned i;
    logic [1:0]  fx;
    logic [1:0]  fy;
    logic        rd;
    logic        avg;
    bit          per_row;
    bit          hold;

    // A row before any first row blends against the zero row left by reset.
    push_word(1'b0, '1, '0, 2'd3, 2'd3, 1'b0, ModeWrite);
    // A block of all-ones bytes, with offsets, rounding and mode changing
    // from row to row; the full-pel copy is the first of them.
    push_word(1'b1, '1, '0, 2'd0, 2'd0, 1'b0, ModeWrite);
    push_word(1'b0, '1, '0, 2'd0, 2'd0, 1'b1, ModeWrite);
    push_word(1'b0, '1, '1, 2'd3, 2'd3, 1'b0, ModeAvg);
    push_word(1'b0, '1, '0, 2'd1, 2'd2, 1'b1, ModeWrite);
    push_word(1'b0, '1, '0, 2'd2, 2'd1, 1'b1, ModeAvg);
    // Rows past the fourth give nothing.
    push_word(1'b0, 40'h12_34_56_78_9A, '1, 2'd1, 2'd1, 1'b0, ModeWrite);
    push_word(1'b0, '0, '0, 2'd3, 2'd0, 1'b1, ModeAvg);
    // A zero block with alternating rows, pure horizontal and vertical steps, then diagonal ones.
    push_word(1'b1, '0, '0, 2'd0, 2'd0, 1'b0, ModeWrite);
    push_word(1'b0, 40'hFF_00_FF_00_FF, '1, 2'd3, 2'd0, 1'b0, ModeWrite);
    push_word(1'b0, 40'h00_FF_00_FF_00, '1, 2'd0, 2'd3, 1'b1, ModeWrite);
    push_word(1'b0, 40'hFF_00_FF_00_FF, '0, 2'd3, 2'd3, 1'b1, ModeWrite);
    push_word(1'b0, 40'h00_FF_00_FF_00, '1, 2'd2, 2'd2, 1'b1, ModeAvg);
    // A block cut short by a new first row, then a complete one.
    push_word(1'b1, 40'h80_7F_01_FE_55, '0, 2'd1, 2'd3, 1'b0, ModeWrite);
    push_word(1'b0, 40'hAA_55_AA_55_AA, '0, 2'd1, 2'd3, 1'b0, ModeWrite);
    push_word(1'b1, 40'h01_02_03_04_05, '0, 2'd2, 2'd2, 1'b0, ModeAvg);
    for (i = 0; i < 4; i++) begin
      push_word(1'b0, 40'hF0_E1_D2_C3_B4 >> i, 32'h7F80_01FE, 2'd2, 2'd2, i[0], ModeAvg);
    end

    // Random part: mostly complete blocks with random content, with some
    // blocks cut short, stray rows and rows past the fourth mixed in.
    made = 0;
    blk  = 0;
    while (made < RandomRows) begin
      kind    = $urandom_range(99);
      fx      = 2'($urandom_range(3));
      fy      = 2'($urandom_range(3));
      rd      = 1'($urandom_range(1));
      avg     = 1'($urandom_range(1));
      per_row = ($urandom_range(4) == 0);
      // Now and then the fetcher waits for the whole pipe to empty.
      hold    = (blk == 0) || ($urandom_range(39) == 0);
      blk++;
      if (kind < 90) begin
        n = (kind < 80) ? 4 : $urandom_range(3);
        push_word(1'b1, pick_src(), pick_dst(), fx, fy, rd, avg, hold);
        made++;
        for (i = 0; i < n; i++) begin
          if (per_row) begin
            fx  = 2'($urandom_range(3));
            fy  = 2'($urandom_range(3));
            rd  = 1'($urandom_range(1));
            avg = 1'($urandom_range(1));
          end
          push_word(1'b0, pick_src(), pick_dst(), fx, fy, rd, avg);
          made++;
        end
        if (n == 4 && $urandom_range(6) == 0) begin
          for (i = 0; i <= $urandom_range(1); i++) begin
            push_word(1'b0, pick_src(), pick_dst(), 2'($urandom_range(3)),
                      2'($urandom_range(3)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
            made++;
          end
        end
      end else begin
        n = 1 + $urandom_range(2);
        for (i = 0; i < n; i++) begin
          push_word(1'b0, pick_src(), pick_dst(), 2'($urandom_range(3)),
                    2'($urandom_range(3)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), hold);
          hold = 1'b0;
          made++;
        end
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_rows.size() != 0 || row_valid) @(posedge clk_i);
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_rows.size() != 0) begin
      report_mismatch($sformatf("%0d predicted words never arrived", expected_rows.size()));
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
